// ----- src/cfc_pkg.sv -----
package cfc_pkg;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_SLASH
    } char_class_t;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_TRAIL,
        PH_SUFFIX
    } phase_t;

    typedef struct packed {
        logic        has_char;
        char_class_t cls;
        logic        last;
    } token_t;

    localparam logic [7:0] SLASH_CODE  = 8'h2F;
    localparam logic [1:0] PREFIX_MAX  = 2'd2;
    localparam logic [1:0] RUN_MAX     = 2'd3;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cls;
        cls = CLS_OTHER;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
        begin
            cls = CLS_LETTER;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            cls = CLS_DIGIT;
        end
        else if (c == SLASH_CODE)
        begin
            cls = CLS_SLASH;
        end
        return cls;
    endfunction

endpackage

// ----- src/cfc_front.sv -----
module cfc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              has_char,
    input  logic              last,
    output logic              tok_valid,
    input  logic              tok_ready,
    output cfc_pkg::token_t   tok
);

    logic            tok_valid_reg;
    logic            tok_valid_next;
    cfc_pkg::token_t tok_reg;
    logic            in_xfer;

    assign in_ready = !tok_valid_reg || tok_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        tok_valid_next = in_xfer || (tok_valid_reg && !tok_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    // classify on the way in so the back end sees only a 2-bit class
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tok_reg.has_char <= has_char;
            tok_reg.cls      <= cfc_pkg::classify(char_code);
            tok_reg.last     <= last;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

// ----- src/cfc_queue.sv -----
module cfc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  cfc_pkg::token_t   push_tok,
    output logic              pop_valid,
    input  logic              pop_ready,
    output cfc_pkg::token_t   pop_tok
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cfc_pkg::token_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ----- src/cfc_back.sv -----
module cfc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  cfc_pkg::token_t   tok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              valid_res
);

    cfc_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      run_reg, run_next;
    logic            failed_reg, failed_next;
    logic            out_valid_reg, out_valid_next;
    logic            res_reg, res_next;
    logic            take;

    // a non-last token never produces a result, so only a word end waits on the output
    assign tok_ready = !tok.last || !out_valid_reg || out_ready;
    assign take      = tok_valid && tok_ready;

    always_comb
    begin
        cfc_pkg::phase_t ph;
        logic [1:0]      run;
        logic            fail;

        ph   = phase_reg;
        run  = run_reg;
        fail = failed_reg;

        if (take && tok.has_char && !failed_reg)
        begin
            unique case (phase_reg)
                cfc_pkg::PH_PREFIX:
                begin
                    if (tok.cls == cfc_pkg::CLS_LETTER && run_reg < cfc_pkg::PREFIX_MAX)
                    begin
                        run = run_reg + 2'd1;
                    end
                    else if (tok.cls == cfc_pkg::CLS_DIGIT && run_reg != 2'd0)
                    begin
                        ph  = cfc_pkg::PH_TRAIL;
                        run = 2'd0;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                cfc_pkg::PH_TRAIL:
                begin
                    if (tok.cls == cfc_pkg::CLS_LETTER && run_reg < cfc_pkg::RUN_MAX)
                    begin
                        run = run_reg + 2'd1;
                    end
                    else if (tok.cls == cfc_pkg::CLS_SLASH && run_reg != 2'd0)
                    begin
                        ph  = cfc_pkg::PH_SUFFIX;
                        run = 2'd0;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                cfc_pkg::PH_SUFFIX:
                begin
                    if (tok.cls == cfc_pkg::CLS_LETTER && run_reg < cfc_pkg::RUN_MAX)
                    begin
                        run = run_reg + 2'd1;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase
        end

        phase_next     = ph;
        run_next       = run;
        failed_next    = fail;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (take && tok.last)
        begin
            res_next = !fail && run != 2'd0
                       && (ph == cfc_pkg::PH_TRAIL || ph == cfc_pkg::PH_SUFFIX);
            out_valid_next = 1'b1;
            // start the next word fresh
            phase_next  = cfc_pkg::PH_PREFIX;
            run_next    = 2'd0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cfc_pkg::PH_PREFIX;
            run_reg       <= 2'd0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_reg;

endmodule

// ----- src/callsign_format_checker.sv -----
// Callsign format checker: takes one character per cycle while in_ready is high
// and, on the item with last set, returns one result telling whether the word is
// one or two letters, a digit, one to three letters, and optionally a slash with
// one to three letters. A new item may be accepted on every clock while in_ready
// is high. Each result passes through the classify register, the token queue
// and the result register. The queue (QUEUE_DEPTH entries) lets input keep
// flowing while a result waits for out_ready.
module callsign_format_checker
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       has_char,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res
);

    logic            f_valid, f_ready;
    cfc_pkg::token_t f_tok;
    logic            q_valid, q_ready;
    cfc_pkg::token_t q_tok;

    cfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .has_char  (has_char),
        .last      (last),
        .tok_valid (f_valid),
        .tok_ready (f_ready),
        .tok       (f_tok)
    );

    cfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_tok   (f_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_tok    (q_tok)
    );

    cfc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res)
    );

endmodule

// ----- src/cfc_checker.sv -----
module cfc_checker
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       last,
    input logic       out_valid,
    input logic       out_ready,
    input logic       valid_res
);

    localparam logic [7:0] MAX_PENDING = 8'(QUEUE_DEPTH + 2);

    logic [7:0] pending_reg;
    logic       word_end;
    logic       res_xfer;

    assign word_end = in_valid && in_ready && last;
    assign res_xfer = out_valid && out_ready;

    // words accepted whose result has not been transferred yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 8'd0;
        end
        else if (word_end && !res_xfer)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (res_xfer && !word_end)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result shown with no word pending");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= MAX_PENDING)
        else $error("more words in flight than storage allows");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res))
        else $error("stalled result dropped or changed");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 8'd0 && !out_valid && !in_ready |=> in_ready || pending_reg != 8'd0)
        else $error("input stalled with nothing waiting on output");

endmodule

bind callsign_format_checker cfc_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cfc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res)
);

// ----- dv/callsign_format_checker_tb.sv -----
module callsign_format_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1700;

    typedef struct packed {
        logic [7:0] code;
        logic       has;
        logic       fin;
        logic       known;
        logic       known_ok;
    } stim_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'h00;
    logic       has_char = 1'b0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       valid_res;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;

    // Callsign tracker state, mirrors the block between word boundaries
    cfc_pkg::phase_t cs_phase = cfc_pkg::PH_PREFIX;
    logic [1:0]      cs_letters = 2'd0;
    logic            cs_broken = 1'b0;

    logic       verdicts_due [$];
    stim_t      word_q [$];
    logic       oldest_verdict;

    // Rows with known set carry a verdict, in known_ok, that is plain from the pattern
    stim_t directed_rows [0:22] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h5A, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h30, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h7A, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h2F, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h5A, 1'b1, 1'b1, 1'b1, 1'b1},
        '{8'h4B, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h39, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'h57, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h31, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h2F, 1'b1, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{8'h4E, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hA5, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h32, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h58, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h42, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h43, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    callsign_format_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .has_char  (has_char),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Advance the callsign tracker by one transfer; on the word's end give the verdict
    function automatic void step_callsign(input logic [7:0] c, input logic has,
                                          input logic fin, output logic done,
                                          output logic match);
        logic alpha;
        logic numeral;
        alpha   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        numeral = (c >= 8'h30 && c <= 8'h39);
        if (has && !cs_broken)
        begin
            case (cs_phase)
                cfc_pkg::PH_PREFIX:
                begin
                    if (alpha && cs_letters < cfc_pkg::PREFIX_MAX)
                    begin
                        cs_letters = cs_letters + 2'd1;
                    end
                    else if (numeral && cs_letters != 2'd0)
                    begin
                        cs_phase   = cfc_pkg::PH_TRAIL;
                        cs_letters = 2'd0;
                    end
                    else
                    begin
                        cs_broken = 1'b1;
                    end
                end
                cfc_pkg::PH_TRAIL:
                begin
                    if (alpha && cs_letters < cfc_pkg::RUN_MAX)
                    begin
                        cs_letters = cs_letters + 2'd1;
                    end
                    else if (c == cfc_pkg::SLASH_CODE && cs_letters != 2'd0)
                    begin
                        cs_phase   = cfc_pkg::PH_SUFFIX;
                        cs_letters = 2'd0;
                    end
                    else
                    begin
                        cs_broken = 1'b1;
                    end
                end
                cfc_pkg::PH_SUFFIX:
                begin
                    if (alpha && cs_letters < cfc_pkg::RUN_MAX)
                    begin
                        cs_letters = cs_letters + 2'd1;
                    end
                    else
                    begin
                        cs_broken = 1'b1;
                    end
                end
                default:
                begin
                    cs_broken = 1'b1;
                end
            endcase
        end
        done  = fin;
        match = !cs_broken
                && (cs_phase == cfc_pkg::PH_TRAIL || cs_phase == cfc_pkg::PH_SUFFIX)
                && cs_letters != 2'd0;
        if (fin)
        begin
            cs_phase   = cfc_pkg::PH_PREFIX;
            cs_letters = 2'd0;
            cs_broken  = 1'b0;
        end
    endfunction

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            return pick_letter();
        end
        else if (roll < 55)
        begin
            return 8'h30 + 8'($urandom_range(9));
        end
        else if (roll < 65)
        begin
            return cfc_pkg::SLASH_CODE;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic stim_t make_item(input logic [7:0] c, input logic has, input logic fin);
        stim_t it;
        it.code     = c;
        it.has      = has;
        it.fin      = fin;
        it.known    = 1'b0;
        it.known_ok = 1'b0;
        return it;
    endfunction

    // Mostly well-formed callsigns with random content, some mutated or cut short,
    // the rest noise and empty words
    task automatic queue_word();
        logic [7:0]  chars [$];
        int unsigned kind;
        int unsigned pos;
        logic        tail_blank;
        kind = $urandom_range(99);
        if (kind < 5)
        begin
            word_q.push_back(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
            return;
        end
        if (kind < 20)
        begin
            repeat ($urandom_range(1, 8)) chars.push_back(pick_char());
        end
        else
        begin
            repeat ($urandom_range(1, 2)) chars.push_back(pick_letter());
            chars.push_back(8'h30 + 8'($urandom_range(9)));
            repeat ($urandom_range(1, 3)) chars.push_back(pick_letter());
            if ($urandom_range(99) < 40)
            begin
                chars.push_back(cfc_pkg::SLASH_CODE);
                repeat ($urandom_range(0, 3)) chars.push_back(pick_letter());
            end
            if ($urandom_range(99) < 25)
            begin
                pos = $urandom_range(chars.size() - 1);
                if ($urandom_range(1))
                begin
                    chars[pos] = pick_char();
                end
                else
                begin
                    chars.insert(pos, pick_letter());
                end
            end
            if ($urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, chars.size() - 1)) void'(chars.pop_back());
            end
        end
        tail_blank = ($urandom_range(99) < 15);
        foreach (chars[i])
        begin
            if ($urandom_range(99) < 5)
            begin
                word_q.push_back(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
            end
            word_q.push_back(make_item(chars[i], 1'b1, !tail_blank && i == chars.size() - 1));
        end
        if (tail_blank)
        begin
            word_q.push_back(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
        end
    endtask

    task automatic send_item(input stim_t it);
        logic done;
        logic match;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= it.code;
        has_char  <= it.has;
        last      <= it.fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        step_callsign(it.code, it.has, it.fin, done, match);
        if (done)
        begin
            verdicts_due.push_back(it.known ? it.known_ok : match);
        end
    endtask

    // Check each result transfer, then pick the next out_ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                flag_mismatch($sformatf("result %0b with no word pending", valid_res));
            end
            else
            begin
                oldest_verdict = verdicts_due.pop_front();
                if (valid_res !== oldest_verdict)
                begin
                    flag_mismatch($sformatf("valid_res %0b, expected %0b",
                                            valid_res, oldest_verdict));
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        int unsigned sent;
        stim_t       it;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i]);
        end
        sent = 0;
        // Finish the word in progress once the item budget is spent
        while (sent < RANDOM_ITEMS || word_q.size() != 0)
        begin
            if (word_q.size() == 0)
            begin
                queue_word();
            end
            it = word_q.pop_front();
            case (sent * 4 / RANDOM_ITEMS)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            send_item(it);
            if (it.has || it.fin)
            begin
                sent++;
            end
        end
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
